FILE: hdl/fed_pkg.sv
// ============================================================================
// fed_pkg : shared types and constants of the feedback echo delay
// Sample and gain formats, delay ring geometry, register indexes and the
// item record passed from the front end to the back end.
// ============================================================================
`default_nettype none

package fed_pkg;

    // sample and gain formats
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 16;
    localparam int DELAY_W      = 17;

    // delay ring, a power of two so the pointer wraps by itself
    localparam int BUFFER_DEPTH = 131072;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

    // configuration port
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = DELAY_W;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(42598);
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(17640);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN  = 1'b0,
        CFG_DELAY = 1'b1
    } t_cfg_index;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [ADDR_W-1:0]          t_addr;

    // one classified sample on its way to the back end
    typedef struct packed {
        t_sample sample;
        t_addr   wr_addr;
        t_addr   rd_addr;
        logic    rd_ok;     // delayed entry already written since reset
    } t_fed_item;

    // queue status seen by both ends
    typedef struct packed {
        logic valid;
        logic full;
    } t_fed_qstat;

endpackage

`default_nettype wire

FILE: hdl/feedback_echo_delay.sv
// ============================================================================
// feedback_echo_delay : feedback comb echo on a sample stream
// Each sample gives y = floor((x + g * d) / 2), d being the output written
// delay_samples transfers earlier; outputs are kept in a 128k-entry ring.
// ============================================================================
//
// Usage:
//   Input samples arrive on the s_axis stream, results leave on the m_axis
//   stream, one result per input, in order. The feedback gain (index 0,
//   unsigned Q0.16) and the delay in samples (index 1, modulo the ring depth)
//   are written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
//   Throughput is one sample per cycle while the receiver keeps m_axis
//   tready high, set by the single ring read and write per sample and the
//   combinational multiply-add loop; with a delay of one the previous
//   result is forwarded around the ring.
//   Reset clears the write pointer and a ring-filled flag; slots not yet
//   written since reset read as zero, so no clearing pass is needed and the
//   block takes samples as soon as reset is released.
//   When the receiver stalls, the output holds and a two-entry queue absorbs
//   further samples before s_axis tready drops.
//
`default_nettype none

module feedback_echo_delay (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [fed_pkg::SAMPLE_W-1:0]    i_s_axis_tdata,   // [15:0] sample_in
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [fed_pkg::SAMPLE_W-1:0]         o_m_axis_tdata,   // [15:0] sample_out
    input  wire logic                            i_cfg_we,
    input  wire logic [fed_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [fed_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [fed_pkg::GAIN_W-1:0]  r_gain;
    logic [fed_pkg::DELAY_W-1:0] r_delay;
    logic                        push;
    logic                        pop;
    fed_pkg::t_fed_item          item;
    fed_pkg::t_fed_item          head;
    fed_pkg::t_fed_qstat         qstat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= fed_pkg::GAIN_RESET;
            r_delay <= fed_pkg::DELAY_RESET;
        end else if (i_cfg_we) begin
            case (fed_pkg::t_cfg_index'(i_cfg_index))
                fed_pkg::CFG_GAIN: begin
                    r_gain <= i_cfg_data[fed_pkg::GAIN_W-1:0];
                end
                fed_pkg::CFG_DELAY: begin
                    r_delay <= i_cfg_data[fed_pkg::DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // intake and classification
    fed_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_delay         (r_delay),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_item          (item)
    );

    // decoupling queue
    fed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // ring, arithmetic and output
    fed_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (qstat),
        .i_head          (head),
        .o_pop           (pop),
        .i_gain          (r_gain),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: hdl/fed_ram.sv
// ============================================================================
// fed_ram : generic single-port-write, single-port-read memory
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ============================================================================
`default_nettype none

module fed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fed_front.sv
// ============================================================================
// fed_front : sample intake and ring address classification
// Takes input transfers, assigns each sample its write slot, works out the
// delayed read slot and whether that slot has been written since reset.
// ============================================================================
`default_nettype none

module fed_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [fed_pkg::SAMPLE_W-1:0] i_s_axis_tdata,   // [15:0] sample_in
    input  wire logic [fed_pkg::DELAY_W-1:0]  i_delay,
    input  wire fed_pkg::t_fed_qstat          i_qstat,
    output logic                              o_push,
    output fed_pkg::t_fed_item                o_item
);

    fed_pkg::t_addr              r_wp;
    fed_pkg::t_addr              n_wp;
    logic                        r_full;
    logic                        n_full;
    logic                        accept;
    fed_pkg::t_addr              dly;
    logic [fed_pkg::ADDR_W:0]    diff;

    // intake handshake
    assign o_s_axis_tready = !i_qstat.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = accept;

    // read slot lies dly behind the write slot; no borrow means no wrap
    assign dly  = i_delay[fed_pkg::ADDR_W-1:0];
    assign diff = {1'b0, r_wp} - {1'b0, dly};

    always_comb begin
        o_item.sample  = fed_pkg::t_sample'(i_s_axis_tdata[fed_pkg::SAMPLE_W-1:0]);
        o_item.wr_addr = r_wp;
        o_item.rd_addr = diff[fed_pkg::ADDR_W-1:0];
        o_item.rd_ok   = r_full || (!diff[fed_pkg::ADDR_W] && (dly != '0));
    end

    // write pointer and ring filled flag
    always_comb begin
        n_wp   = r_wp;
        n_full = r_full;
        if (accept) begin
            n_wp = r_wp + 1'b1;
            if (r_wp == '1) begin
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_full <= n_full;
        end
    end

`ifndef ASSERT_OFF
    a_wp_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_wp == fed_pkg::t_addr'($past(r_wp) + 1'b1)))
        else $error("write pointer did not step by one");

    a_full_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("ring filled flag dropped without reset");
`endif

endmodule

`default_nettype wire

FILE: hdl/fed_queue.sv
// ============================================================================
// fed_queue : two-entry queue between front and back end
// Lets the intake keep taking samples while the back end waits on its
// receiver.
// ============================================================================
`default_nettype none

module fed_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire fed_pkg::t_fed_item i_item,
    input  wire logic               i_pop,
    output fed_pkg::t_fed_item      o_head,
    output fed_pkg::t_fed_qstat     o_qstat
);

    fed_pkg::t_fed_item r_slot [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic [1:0]         n_count;

    assign o_head        = r_slot[r_rd_ptr];
    assign o_qstat.valid = (r_count != 2'd0);
    assign o_qstat.full  = (r_count == 2'd2);

    // occupancy
    assign n_count = r_count + 2'(i_push) - 2'(i_pop);

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue occupancy beyond two entries");
`endif

endmodule

`default_nettype wire

FILE: hdl/fed_back.sv
// ============================================================================
// fed_back : delay ring, feedback arithmetic and output register
// Reads the delayed output, forms (x + g * d) / 2 by floor shift, writes the
// result back into the ring and presents it on the output stream.
// ============================================================================
`default_nettype none

module fed_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fed_pkg::t_fed_qstat          i_qstat,
    input  wire fed_pkg::t_fed_item           i_head,
    output logic                              o_pop,
    input  wire logic [fed_pkg::GAIN_W-1:0]   i_gain,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic [fed_pkg::SAMPLE_W-1:0]      o_m_axis_tdata    // [15:0] sample_out
);

    localparam int PROD_W  = fed_pkg::SAMPLE_W + fed_pkg::GAIN_W + 1;
    localparam int TOTAL_W = PROD_W + 1;

    fed_pkg::t_fed_item            r_s1;
    logic                          r_s1_valid;
    logic                          n_s1_valid;
    logic                          r_fwd;
    logic                          n_fwd;
    logic                          s1_adv;
    fed_pkg::t_sample              r_last_y;
    fed_pkg::t_sample              ram_q;
    fed_pkg::t_sample              d;
    logic signed [PROD_W-1:0]      prod;
    logic signed [TOTAL_W-1:0]     total;
    fed_pkg::t_sample              y;
    logic                          r_out_valid;
    logic                          n_out_valid;
    fed_pkg::t_sample              r_out_data;

    // stage advance and queue pop
    assign s1_adv = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_pop  = i_qstat.valid && (!r_s1_valid || s1_adv);

    // the previous sample is written on the same edge as this read is issued
    assign n_fwd = r_s1_valid && s1_adv && (i_head.rd_addr == r_s1.wr_addr);

    // delay ring
    fed_ram #(
        .WIDTH (fed_pkg::SAMPLE_W),
        .DEPTH (fed_pkg::BUFFER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.wr_addr),
        .i_wdata (y),
        .i_re    (o_pop),
        .i_raddr (i_head.rd_addr),
        .o_rdata (ram_q)
    );

    // delayed sample: forwarded, from the ring, or zero if never written
    always_comb begin
        if (r_fwd) begin
            d = r_last_y;
        end else if (r_s1.rd_ok) begin
            d = ram_q;
        end else begin
            d = '0;
        end
    end

    // x * 2^16 + g * d, floor shift by 17
    always_comb begin
        prod  = $signed({1'b0, i_gain}) * d;
        total = {{2{r_s1.sample[fed_pkg::SAMPLE_W-1]}}, r_s1.sample, {fed_pkg::GAIN_W{1'b0}}}
              + {prod[PROD_W-1], prod};
        y     = total[fed_pkg::SAMPLE_W+fed_pkg::GAIN_W:fed_pkg::GAIN_W+1];
    end

    // stage and output valid flags
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_pop) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_fwd <= n_fwd;
            end else if (s1_adv) begin
                r_fwd <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_head;
        end
        if (s1_adv) begin
            r_last_y   <= y;
            r_out_data <= y;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_fwd_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward flag set with no sample in compute stage");

    a_out_after_adv : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("computed sample did not reach the output register");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/feedback_echo_delay_test.sv
`timescale 1ns / 1ps
// ============================================================================
// feedback_echo_delay_test : self-checking regression of the feedback echo
// Streams samples through the echo under a series of gain and delay settings,
// tracks the delay ring in a scoreboard and checks every echoed sample in order.
// ============================================================================

module feedback_echo_delay_test;

    localparam int HALF_PERIOD = 10;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 96;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 108;
    localparam int GAP_MAX     = 18;

    localparam logic [fed_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
        {1'b0, {(fed_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic [fed_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
        {1'b1, {(fed_pkg::SAMPLE_W-1){1'b0}}};
    localparam logic [fed_pkg::DELAY_W-1:0]  DELAY_MAX  = '1;

    // ring tracker: mirrors the delay memory and holds the echoes still owed
    class echo_tracker;
        fed_pkg::t_sample            ring [fed_pkg::BUFFER_DEPTH];
        int unsigned                 wr_ptr;
        logic [fed_pkg::GAIN_W-1:0]  gain;
        logic [fed_pkg::DELAY_W-1:0] delay;
        fed_pkg::t_sample            pending_echoes [$];
        int unsigned                 mismatches;
        int unsigned                 checked;

        function void clear();
            for (int i = 0; i < fed_pkg::BUFFER_DEPTH; i++) ring[i] = '0;
            wr_ptr = 0;
            gain = fed_pkg::GAIN_RESET;
            delay = fed_pkg::DELAY_RESET;
            pending_echoes.delete();
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_register(fed_pkg::t_cfg_index idx,
                                   logic [fed_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                fed_pkg::CFG_GAIN:  gain = value[fed_pkg::GAIN_W-1:0];
                fed_pkg::CFG_DELAY: delay = value[fed_pkg::DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        // echo of one input transfer: floor((x * 2^16 + g * d) / 2^17)
        function void take_sample(fed_pkg::t_sample x);
            int unsigned      rd_ptr;
            int unsigned      dly;
            longint           acc;
            fed_pkg::t_sample y;
            dly = delay;
            // a zero remainder reads the slot about to be overwritten
            rd_ptr = (wr_ptr + fed_pkg::BUFFER_DEPTH - dly % fed_pkg::BUFFER_DEPTH)
                     % fed_pkg::BUFFER_DEPTH;
            acc = (longint'(x) <<< fed_pkg::GAIN_W)
                  + longint'(gain) * longint'(ring[rd_ptr]);
            acc = acc >>> (fed_pkg::GAIN_W + 1);
            y = acc[fed_pkg::SAMPLE_W-1:0];
            ring[wr_ptr] = y;
            wr_ptr = (wr_ptr + 1) % fed_pkg::BUFFER_DEPTH;
            pending_echoes.push_back(y);
        endfunction

        function void match_output(fed_pkg::t_sample y);
            fed_pkg::t_sample want;
            if (pending_echoes.size() == 0) begin
                $error("sample_out unexpected: expected none, actual %0d", y);
                mismatches++;
            end else begin
                want = pending_echoes.pop_front();
                checked++;
                if (y !== want) begin
                    $error("sample_out mismatch: expected %0d, actual %0d", want, y);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic [fed_pkg::SAMPLE_W-1:0]    s_data    = '0;
    logic                            m_ready   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [fed_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fed_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            s_ready;
    logic                            m_valid;
    logic [fed_pkg::SAMPLE_W-1:0]    m_data;

    echo_tracker echoes = new();

    int  tx_max_gap    = 0;
    int  rx_max_gap    = 0;
    bit  hold_off_req  = 1'b0;
    int unsigned sent_count     = 0;
    int unsigned settings_count = 0;

    feedback_echo_delay DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),      // [15:0] sample_in
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),      // [15:0] sample_out
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // 20 ns clock
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // one input transfer after a random gap, returns at the falling edge
    task automatic send_sample(input logic [fed_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        do @(posedge i_clk); while (!s_ready);
        echoes.take_sample(value);
        sent_count++;
        @(negedge i_clk);
    endtask

    // stop offering and wait until every echo has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (echoes.pending_echoes.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // gain then delay on back-to-back cycles, enable held across both
    task automatic apply_settings(input logic [fed_pkg::GAIN_W-1:0] gain,
                                  input logic [fed_pkg::DELAY_W-1:0] delay);
        cfg_we    <= 1'b1;
        cfg_index <= fed_pkg::CFG_GAIN;
        cfg_data  <= fed_pkg::CFG_DATA_W'(gain);
        @(negedge i_clk);
        cfg_index <= fed_pkg::CFG_DELAY;
        cfg_data  <= delay;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        echoes.set_register(fed_pkg::CFG_GAIN, fed_pkg::CFG_DATA_W'(gain));
        echoes.set_register(fed_pkg::CFG_DELAY, delay);
        settings_count++;
    endtask

    // mostly random samples, with extremes and silence mixed in
    function automatic logic [fed_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return fed_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_gap_limit();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return GAP_MAX;
        endcase
    endfunction

    // result sink with random stalls and the occasional long hold-off
    initial begin : result_sink
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                gap = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                gap = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            echoes.match_output(m_data);
            @(negedge i_clk);
        end
    end

    // watchdog on cycles with no transfer on either stream
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("feedback_echo_delay regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [fed_pkg::GAIN_W-1:0]  gain;
        logic [fed_pkg::DELAY_W-1:0] delay;
        echoes.clear();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field extremes and alternating bit patterns
        rx_max_gap = 3;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);
        send_sample(fed_pkg::SAMPLE_W'(1));
        send_sample({(fed_pkg::SAMPLE_W/2){2'b01}});
        send_sample({(fed_pkg::SAMPLE_W/2){2'b10}});
        drain();

        // full gain at a delay of one, back to back, to drive the loop hard
        apply_settings('1, fed_pkg::DELAY_W'(1));
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (4) send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        drain();

        // zero delay reads the slot about to be written
        apply_settings('0, '0);
        repeat (3) send_sample(pick_sample());
        drain();

        // longest delay reads far back into the ring
        apply_settings('1, DELAY_MAX);
        repeat (3) send_sample(pick_sample());
        drain();

        // random phases under varied settings
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       gain = '1;
                1:       gain = '0;
                2:       gain = fed_pkg::GAIN_RESET;
                default: gain = fed_pkg::GAIN_W'($urandom);
            endcase
            case (phase)
                0:       delay = fed_pkg::DELAY_W'(1);
                1:       delay = fed_pkg::DELAY_W'(2);
                2:       delay = '0;
                3:       delay = DELAY_MAX;
                4:       delay = fed_pkg::DELAY_W'($urandom);
                5:       delay = fed_pkg::DELAY_W'($urandom_range(1, 16));
                default: delay = fed_pkg::DELAY_W'($urandom_range(1, 64));
            endcase
            apply_settings(gain, delay);
            tx_max_gap = pick_gap_limit();
            rx_max_gap = pick_gap_limit();
            // back-pressure: receiver holds off while the sender keeps going
            if (phase == 0 || phase == 5) begin
                tx_max_gap = 0;
                hold_off_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("checked %0d echoes of %0d samples over %0d gain/delay settings",
                 echoes.checked, sent_count, settings_count);
        $display("settings spanned zero and full gain, delays of zero, one, short and maximum");
        if (echoes.mismatches == 0 && echoes.pending_echoes.size() == 0) begin
            $display("feedback_echo_delay regression: pass");
        end else begin
            $display("feedback_echo_delay regression: fail");
        end
        $finish;
    end

endmodule
